### src/simt_pkg.sv
// package for the scaled-instance match table: sizes, codes and record types
package simt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pixel;
    logic [15:0] point;
    logic [15:0] width;
    logic [15:0] font;
    logic [15:0] bitmap;
  } rec_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    rec_t            wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

### src/scaled_instance_match_table_top.sv
// top level of the scaled-instance match table: request sequencer and result register
//
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_ready_o    req_type_i .. bitmap_handle_i
//  result    out        out_valid_o / out_ready_i  status_o .. entry_count_o
//
//  add: the record is written to the store at accept, with no scan
//  find: reads the records from slot 0 up and stops at the first hit, or after the last record on a miss
//  remove: scans like find but matches on the font handle, then one cycle per record moved down on a hit
//  the record store port (one read, one write a cycle, read data registered) sets the pace
//  reset empties the table at once; record contents stay undefined until written
//  a waiting result does not hold off the next request; it stalls only a finishing one
module scaled_instance_match_table_top
  import simt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] req_x_i,
  input  logic signed [15:0] req_y_i,
  input  logic signed [15:0] req_pixel_i,
  input  logic signed [15:0] req_point_i,
  input  logic signed [15:0] req_width_i,
  input  logic [15:0]        font_handle_i,
  input  logic [15:0]        bitmap_handle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [3:0]         hit_index_o,
  output logic [15:0]        hit_font_o,
  output logic [15:0]        hit_bitmap_o,
  output logic [4:0]         entry_count_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic [1:0]      req_kind_q, req_kind_d;
  rec_t            key_q, key_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;
  logic [15:0]     res_font_q, res_font_d;
  logic [15:0]     res_bmp_q, res_bmp_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [3:0]      out_idx_q, out_idx_d;
  logic [15:0]     out_font_q, out_font_d;
  logic [15:0]     out_bmp_q, out_bmp_d;
  logic [4:0]      out_count_q, out_count_d;

  mem_req_t        mem_req;
  rec_t            rdata;
  rec_t            in_rec;

  logic            in_fire;
  logic            out_free;
  logic            issue_scan;
  logic            issue_shift;
  logic            match_find;
  logic            match_font;
  logic            hit;
  logic            table_full;

  simt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_rec = '{
    x:      req_x_i,
    y:      req_y_i,
    pixel:  req_pixel_i,
    point:  req_point_i,
    width:  req_width_i,
    font:   font_handle_i,
    bitmap: bitmap_handle_i
  };

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign table_full  = (count_q == CntW'(TableDepth));
  assign issue_scan  = (scan_q < count_q);
  assign issue_shift = (scan_q <= count_q);

  assign match_find = (rdata.x == key_q.x) && (rdata.y == key_q.y) &&
                      ((rdata.width == key_q.width) || (rdata.width == '0) ||
                       (key_q.width == '0)) &&
                      ((rdata.pixel == key_q.pixel) || (rdata.point == key_q.point));
  assign match_font = (rdata.font == key_q.font);
  assign hit        = pend_q && ((req_kind_q == REQ_REMOVE) ? match_font : match_find);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_REMOVE || req_type_i == REQ_FIND) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (req_kind_q == REQ_REMOVE) ? S_SHIFT : S_RESP;
        end else if (!pend_q && !issue_scan) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (!pend_q && !issue_shift) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    count_d      = count_q;
    scan_d       = scan_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    req_kind_d   = req_kind_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_font_d   = res_font_q;
    res_bmp_d    = res_bmp_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_font_d   = out_font_q;
    out_bmp_d    = out_bmp_q;
    out_count_d  = out_count_q;
    mem_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_kind_d = req_type_i;
          key_d      = in_rec;
          scan_d     = '0;
          unique case (req_type_i)
            REQ_ADD: begin
              if (table_full) begin
                res_status_d = STAT_FULL;
                res_idx_d    = '0;
                res_font_d   = '0;
                res_bmp_d    = '0;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_q[IdxW-1:0];
                mem_req.wdata = in_rec;
                count_d       = CntW'(count_q + 1'b1);
                res_status_d  = STAT_OK;
                res_idx_d     = count_q[IdxW-1:0];
                res_font_d    = font_handle_i;
                res_bmp_d     = bitmap_handle_i;
              end
            end
            REQ_REMOVE, REQ_FIND: begin
              res_status_d = STAT_MISS;
            end
            default: begin
              res_status_d = STAT_MISS;
              res_idx_d    = '0;
              res_font_d   = '0;
              res_bmp_d    = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_req.re    = issue_scan;
        mem_req.raddr = scan_q[IdxW-1:0];
        pend_d        = issue_scan;
        pend_idx_d    = scan_q[IdxW-1:0];
        if (issue_scan) begin
          scan_d = CntW'(scan_q + 1'b1);
        end
        if (hit) begin
          res_status_d = STAT_OK;
          res_idx_d    = pend_idx_q;
          res_font_d   = rdata.font;
          res_bmp_d    = rdata.bitmap;
          if (req_kind_q == REQ_REMOVE) begin
            count_d = CntW'(count_q - 1'b1);
          end else begin
            mem_req.re = 1'b0;
            pend_d     = 1'b0;
          end
        end else if (!pend_q && !issue_scan) begin
          res_status_d = STAT_MISS;
          res_idx_d    = '0;
          res_font_d   = '0;
          res_bmp_d    = '0;
        end
      end
      S_SHIFT: begin
        // each record read from the store is written back one slot lower
        mem_req.re    = issue_shift;
        mem_req.raddr = scan_q[IdxW-1:0];
        mem_req.we    = pend_q;
        mem_req.waddr = IdxW'(pend_idx_q - 1'b1);
        mem_req.wdata = rdata;
        pend_d        = issue_shift;
        pend_idx_d    = scan_q[IdxW-1:0];
        if (issue_shift) begin
          scan_d = CntW'(scan_q + 1'b1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = 4'(res_idx_q);
          out_font_d   = res_font_q;
          out_bmp_d    = res_bmp_q;
          out_count_d  = 5'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    req_kind_q   <= req_kind_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_font_q   <= res_font_d;
    res_bmp_q    <= res_bmp_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_font_q   <= out_font_d;
    out_bmp_q    <= out_bmp_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign hit_index_o   = out_idx_q;
  assign hit_font_o    = out_font_q;
  assign hit_bitmap_o  = out_bmp_q;
  assign entry_count_o = out_count_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("record count beyond table depth");

  a_no_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write to the same slot in one cycle");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req_type_i == REQ_ADD && !table_full) |=>
      (count_q == CntW'($past(count_q) + 1'b1)))
    else $error("add did not grow the table by one");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_status_q == STAT_FULL) |-> table_full)
    else $error("full reported with free slots");

  a_shift_only_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (req_kind_q == REQ_REMOVE))
    else $error("records moved outside a remove");

endmodule

### src/simt_mem.sv
// record store: one write and one registered read per cycle
module simt_mem
  import simt_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output rec_t     rdata_o
);

  rec_t mem [TableDepth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### bench/scaled_instance_match_table_top_tb.sv
// testbench for the scaled-instance match table: requests checked against a behavioural table copy
`timescale 1ns / 100ps

module scaled_instance_match_table_top_tb;
  import simt_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    status_e     status;
    logic [3:0]  index;
    logic [15:0] font;
    logic [15:0] bitmap;
    logic [4:0]  count;
  } answer_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i      = '0;
  logic signed [15:0] req_x_i         = '0;
  logic signed [15:0] req_y_i         = '0;
  logic signed [15:0] req_pixel_i     = '0;
  logic signed [15:0] req_point_i     = '0;
  logic signed [15:0] req_width_i     = '0;
  logic [15:0]        font_handle_i   = '0;
  logic [15:0]        bitmap_handle_i = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [1:0]         status_o;
  logic [3:0]         hit_index_o;
  logic [15:0]        hit_font_o;
  logic [15:0]        hit_bitmap_o;
  logic [4:0]         entry_count_o;

  rec_t    held_recs [TableDepth];
  int      held_count = 0;
  answer_t pending_answers [$];

  int n_items = 0, n_stored = 0, n_full = 0, n_found = 0, n_removed = 0, n_missed = 0;
  int mismatch_count = 0;
  int tx_gap_max = 18, rx_stall_max = 18, add_share = 40;
  int rx_stall_left = 0, rx_hold_left = 0;

  scaled_instance_match_table_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .req_x_i         (req_x_i),
    .req_y_i         (req_y_i),
    .req_pixel_i     (req_pixel_i),
    .req_point_i     (req_point_i),
    .req_width_i     (req_width_i),
    .font_handle_i   (font_handle_i),
    .bitmap_handle_i (bitmap_handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .hit_index_o     (hit_index_o),
    .hit_font_o      (hit_font_o),
    .hit_bitmap_o    (hit_bitmap_o),
    .entry_count_o   (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic answer_t table_answer(logic [1:0] kind, logic [15:0] sx, logic [15:0] sy,
                                           logic [15:0] spx, logic [15:0] spt, logic [15:0] sw,
                                           logic [15:0] fh, logic [15:0] bh);
    answer_t a;
    int hit;
    hit = -1;
    a = '{STAT_MISS, 4'd0, 16'd0, 16'd0, 5'd0};
    case (kind)
      REQ_ADD: begin
        if (held_count >= TableDepth) begin
          a.status = STAT_FULL;
          n_full++;
        end else begin
          held_recs[held_count] = '{x: sx, y: sy, pixel: spx, point: spt, width: sw,
                                    font: fh, bitmap: bh};
          a.status = STAT_OK;
          a.index  = 4'(held_count);
          a.font   = fh;
          a.bitmap = bh;
          held_count++;
          n_stored++;
        end
      end
      REQ_REMOVE: begin
        for (int s = 0; s < held_count; s++)
          if (hit < 0 && held_recs[s].font == fh) hit = s;
        if (hit >= 0) begin
          a.status = STAT_OK;
          a.index  = 4'(hit);
          a.font   = held_recs[hit].font;
          a.bitmap = held_recs[hit].bitmap;
          for (int j = hit; j < held_count - 1; j++) held_recs[j] = held_recs[j + 1];
          held_count--;
          n_removed++;
        end
      end
      REQ_FIND: begin
        for (int s = 0; s < held_count; s++)
          if (hit < 0 && held_recs[s].x == sx && held_recs[s].y == sy &&
              (held_recs[s].width == sw || held_recs[s].width == 16'd0 || sw == 16'd0) &&
              (held_recs[s].pixel == spx || held_recs[s].point == spt)) hit = s;
        if (hit >= 0) begin
          a.status = STAT_OK;
          a.index  = 4'(hit);
          a.font   = held_recs[hit].font;
          a.bitmap = held_recs[hit].bitmap;
          n_found++;
        end
      end
      default: ;
    endcase
    if (a.status == STAT_MISS) n_missed++;
    a.count = 5'(held_count);
    return a;
  endfunction

  function automatic logic [15:0] pick_scale();
    logic [15:0] pool [8] = '{16'h0000, 16'h0001, 16'h0048, 16'h004b,
                              16'h0064, 16'h7fff, 16'h8000, 16'hffff};
    return ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_handle();
    logic [15:0] pool [6] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h8000, 16'hffff};
    return ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 5)] : 16'($urandom);
  endfunction

  task automatic send_req(logic [1:0] kind, logic [15:0] sx, logic [15:0] sy,
                          logic [15:0] spx, logic [15:0] spt, logic [15:0] sw,
                          logic [15:0] fh, logic [15:0] bh);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    req_x_i         <= sx;
    req_y_i         <= sy;
    req_pixel_i     <= spx;
    req_point_i     <= spt;
    req_width_i     <= sw;
    font_handle_i   <= fh;
    bitmap_handle_i <= bh;
    do @(posedge clk_i); while (!in_ready_o);
    pending_answers.push_back(table_answer(kind, sx, sy, spx, spt, sw, fh, bh));
    n_items++;
  endtask

  // mostly requests aimed at a held record so that finds and removes hit
  task automatic send_random_request();
    int roll;
    rec_t r;
    logic [1:0] kind;
    logic [15:0] sx, sy, spx, spt, sw, fh;
    roll = $urandom_range(0, 99);
    sx   = pick_scale();
    sy   = pick_scale();
    spx  = pick_scale();
    spt  = pick_scale();
    sw   = pick_scale();
    fh   = pick_handle();
    if (roll < 4) kind = REQ_UNUSED;
    else if (roll < 4 + add_share) kind = REQ_ADD;
    else if (roll < 4 + add_share + (96 - add_share) / 3) kind = REQ_REMOVE;
    else kind = REQ_FIND;
    if (kind != REQ_ADD && held_count > 0 && $urandom_range(0, 9) < 8) begin
      r  = held_recs[$urandom_range(0, held_count - 1)];
      fh = r.font;
      sx = r.x;
      sy = r.y;
      case ($urandom_range(0, 5))
        0: begin
          spx = r.pixel;
          spt = r.point;
          sw  = r.width;
        end
        1: begin
          spx = r.pixel;
          sw  = 16'd0;
        end
        2: begin
          spt = r.point;
          sw  = r.width;
        end
        3: spx = r.pixel;
        4: begin
          spx = r.pixel;
          sy  = r.y ^ (16'd1 << $urandom_range(0, 15));
        end
        default: begin
          spx = r.pixel ^ 16'h0001;
          spt = r.point ^ 16'h8000;
          sw  = r.width;
        end
      endcase
    end
    send_req(kind, sx, sy, spx, spt, sw, fh, 16'($urandom));
  endtask

  task automatic check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("hit_index", 16'(want.index), 16'(hit_index_o));
        check_field("hit_font", want.font, hit_font_o);
        check_field("hit_bitmap", want.bitmap, hit_bitmap_o);
        check_field("entry_count", 16'(want.count), 16'(entry_count_o));
      end
      rx_stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_stall_max);
    end
  end

  // result side: long hold first, then the per-beat stall
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ready_i <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_empty_table();
    send_req(REQ_FIND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_req(REQ_REMOVE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff);
    send_req(REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_add_and_find();
    send_req(REQ_ADD, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
    send_req(REQ_ADD, 16'h7fff, 16'h8000, 16'h1234, 16'h5678, 16'hffff, 16'hffff, 16'h0000);
    send_req(REQ_ADD, 16'h7fff, 16'h8000, 16'h4321, 16'h5678, 16'h0010, 16'h0001, 16'h0002);
    // pixel match
    send_req(REQ_FIND, 16'h7fff, 16'h8000, 16'h1234, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    // point match, earlier record rejected on width
    send_req(REQ_FIND, 16'h7fff, 16'h8000, 16'h0000, 16'h5678, 16'h0010, 16'h0000, 16'h0000);
    // stored width zero matches any width
    send_req(REQ_FIND, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000);
    // requested width zero
    send_req(REQ_FIND, 16'h7fff, 16'h8000, 16'h9999, 16'h5678, 16'h0000, 16'h0000, 16'h0000);
    send_req(REQ_FIND, 16'h7fff, 16'h7fff, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_remove_and_full();
    send_req(REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
    while (held_count < TableDepth)
      send_req(REQ_ADD, pick_scale(), pick_scale(), pick_scale(), pick_scale(), pick_scale(),
               pick_handle(), 16'($urandom));
    send_req(REQ_ADD, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    // first slot goes, the whole table moves down
    send_req(REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_receiver_hold();
    tx_gap_max   = 0;
    rx_hold_left = 150;
    add_share    = 50;
    repeat (16) send_random_request();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin tx_gap_max = 18; rx_stall_max = 18; add_share = 45; end
        1: begin tx_gap_max = 0;  rx_stall_max = 0;  add_share = 60; end
        2: begin tx_gap_max = 18; rx_stall_max = 0;  add_share = 30; end
        3: begin tx_gap_max = 0;  rx_stall_max = 18; add_share = 50; end
        4: begin tx_gap_max = 3;  rx_stall_max = 3;  add_share = 70; end
        default: begin tx_gap_max = 18; rx_stall_max = 18; add_share = 35; end
      endcase
      repeat (102) send_random_request();
    end
  endtask

  task automatic finish_run();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d requests: %0d records stored, %0d adds refused on a full table",
             n_items, n_stored, n_full);
    $display("%0d finds and %0d removes hit, %0d requests answered as not found",
             n_found, n_removed, n_missed);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_gap_max   = 3;
    rx_stall_max = 3;
    test_empty_table();
    test_add_and_find();
    test_remove_and_full();
    test_receiver_hold();
    test_random_mix();
    finish_run();
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
